[hw/rtl/rcw_pkg.sv]
// Shared types and constants for the RIFF/RF64/BW64 chunk walker.
package rcw_pkg;

	// Parse phases
	localparam logic [3:0] PH_TAG      = 4'd0;
	localparam logic [3:0] PH_RSIZE    = 4'd1;
	localparam logic [3:0] PH_WAVE     = 4'd2;
	localparam logic [3:0] PH_CHID     = 4'd3;
	localparam logic [3:0] PH_CHSIZE   = 4'd4;
	localparam logic [3:0] PH_DS_SKIP8 = 4'd5;
	localparam logic [3:0] PH_DS_DATA  = 4'd6;
	localparam logic [3:0] PH_META     = 4'd7;
	localparam logic [3:0] PH_SKIP     = 4'd8;
	localparam logic [3:0] PH_ABORT    = 4'd9;

	// Four-character codes, first byte in the top octet
	localparam logic [31:0] ID_RIFF = 32'h5249_4646;
	localparam logic [31:0] ID_RF64 = 32'h5246_3634;
	localparam logic [31:0] ID_BW64 = 32'h4257_3634;
	localparam logic [31:0] ID_WAVE = 32'h5741_5645;
	localparam logic [31:0] ID_DS64 = 32'h6473_3634;
	localparam logic [31:0] ID_FMT  = 32'h666D_7420;
	localparam logic [31:0] ID_DATA = 32'h6461_7461;
	localparam logic [31:0] ID_DBMD = 32'h6462_6D64;
	localparam logic [31:0] ID_AXML = 32'h6178_6D6C;

	// Seen-mask bits
	localparam int BIT_RIFF = 0;
	localparam int BIT_WAVE = 1;
	localparam int BIT_FMT  = 2;
	localparam int BIT_DATA = 3;
	localparam int BIT_DBMD = 4;
	localparam int BIT_AXML = 5;
	localparam int BIT_DS64 = 6;

	localparam logic [6:0]  MASK_LARGE_OK = 7'h7F;
	localparam logic [6:0]  MASK_PLAIN_OK = 7'h3F;
	localparam logic [31:0] ALL_ONES_SIZE = 32'hFFFF_FFFF;
	localparam logic [31:0] DS64_MIN      = 32'd16;
	localparam logic [15:0] META_MAX_RST  = 16'd6144;

	// Result queue
	localparam int RES_DEPTH = 4;
	localparam int RES_PW    = $clog2(RES_DEPTH);
	localparam int RES_CW    = $clog2(RES_DEPTH + 1);

	typedef struct packed {
		logic        is_verdict;
		logic [7:0]  meta_byte;
		logic        chunk_start;
		logic        file_ok;
		logic [6:0]  chunk_flags;
		logic [15:0] meta_size;
	} res_t;

endpackage

[hw/rtl/riff_chunk_walker.sv]
// Byte-serial RIFF/RF64/BW64 WAVE chunk walker with metadata byte output and verdict.
//
// Usage:
//  - Input channel (in_valid/in_stall): one file byte per transaction, end_of_file
//    set on the last byte of a file. Bytes land in an input register; the
//    parse logic updates all state from that register.
//  - Output channel (out_valid/out_stall): one result per transaction, either a
//    payload byte of a dbmd chunk (is_verdict=0) or the file verdict
//    (is_verdict=1). A final byte inside a dbmd chunk yields two results,
//    the payload byte first, then the verdict.
//  - Config channel (cfg_valid/cfg_ready): writes max_meta_size; always ready.
//    Write it only while the block is idle.
//  - An accepted byte waits in the input register until the queue has room for two
//    results; its results are then written into the queue, which drives out_valid.
//  - Throughput: one byte per cycle. The limit is the 4-entry result queue:
//    a byte is parsed only while at most two results are queued, so bytes
//    that make two results, or a stalled receiver, back up into in_stall.
//  - A receiver stall fills the result queue, then the input register, then
//    in_stall rises; nothing is dropped.
//  - Reset (arst_n low) clears parse state, empties the queue and sets
//    max_meta_size to 6144. After each verdict parse state returns to reset
//    values, ready for the next file; max_meta_size is kept.
module riff_chunk_walker
	import rcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_file,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_verdict,
	output logic [7:0]  meta_byte,
	output logic        chunk_start,
	output logic        file_ok,
	output logic [6:0]  chunk_flags,
	output logic [15:0] meta_size,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] max_meta_size
);

	// ---------------- configuration register ----------------
	logic [15:0] max_meta_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_meta_q <= META_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_meta_q <= max_meta_size;
		end
	end

	// ---------------- input register ----------------
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eof_s1;
	logic [RES_CW-1:0]   count_q;
	logic                proc;
	logic                in_acc;

	// parse only when the queue can take two results
	assign proc     = valid_s1 && (count_q <= RES_CW'(RES_DEPTH - 2));
	assign in_stall = valid_s1 && !proc;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= in_byte;
			eof_s1  <= end_of_file;
		end
	end

	// ---------------- parse state ----------------
	logic [3:0]  phase_q,  phase_d;
	logic [2:0]  fcnt_q,   fcnt_d;
	logic [31:0] chid_q,   chid_d;
	logic [63:0] accum_q,  accum_d;
	logic [63:0] skip_q,   skip_d;
	logic [6:0]  mask_q,   mask_d;
	logic        large_q,  large_d;
	logic        ds64_q,   ds64_d;
	logic [63:0] ldsize_q, ldsize_d;
	logic [15:0] lmeta_q,  lmeta_d;
	logic        abort_q,  abort_d;

	logic [31:0] chid_sh;
	logic [31:0] raw_size;
	logic [31:0] pad_size;
	logic [63:0] skip_dec;
	logic        skip_last;
	logic        meta_emit;
	logic        meta_first;
	logic        hdr_fail;
	logic        verdict_ok;

	assign chid_sh   = {chid_q[23:0], byte_s1};
	assign skip_dec  = skip_q - 64'd1;
	assign skip_last = (skip_q == 64'd1);
	assign meta_emit = (phase_q == PH_META);
	assign meta_first = (skip_q == {48'd0, lmeta_q});

	always_comb begin
		phase_d  = phase_q;
		fcnt_d   = fcnt_q;
		chid_d   = chid_q;
		accum_d  = accum_q;
		skip_d   = skip_q;
		mask_d   = mask_q;
		large_d  = large_q;
		ds64_d   = ds64_q;
		ldsize_d = ldsize_q;
		lmeta_d  = lmeta_q;
		abort_d  = abort_q;
		raw_size = 32'd0;
		pad_size = 32'd0;

		case (phase_q)
			PH_TAG, PH_WAVE, PH_CHID: begin
				chid_d = chid_sh;
				fcnt_d = fcnt_q + 3'd1;
				if (fcnt_q == 3'd3) begin
					fcnt_d = 3'd0;
					if (phase_q == PH_TAG) begin
						if (chid_sh == ID_RIFF || chid_sh == ID_RF64 || chid_sh == ID_BW64) begin
							large_d          = (chid_sh != ID_RIFF);
							mask_d[BIT_RIFF] = 1'b1;
							phase_d          = PH_RSIZE;
						end else begin
							abort_d = 1'b1;
							phase_d = PH_ABORT;
						end
					end else if (phase_q == PH_WAVE) begin
						if (chid_sh == ID_WAVE) begin
							mask_d[BIT_WAVE] = 1'b1;
							phase_d          = PH_CHID;
						end else begin
							abort_d = 1'b1;
							phase_d = PH_ABORT;
						end
					end else begin
						accum_d = 64'd0;
						phase_d = PH_CHSIZE;
					end
				end
			end
			PH_RSIZE: begin
				fcnt_d = fcnt_q + 3'd1;
				if (fcnt_q == 3'd3) begin
					fcnt_d  = 3'd0;
					phase_d = PH_WAVE;
				end
			end
			PH_CHSIZE: begin
				accum_d[{fcnt_q[1:0], 3'b000} +: 8] = accum_q[{fcnt_q[1:0], 3'b000} +: 8] | byte_s1;
				fcnt_d = fcnt_q + 3'd1;
				if (fcnt_q == 3'd3) begin
					raw_size = accum_d[31:0];
					// odd sizes pad by one, all-ones stays as is
					pad_size = (raw_size[0] && raw_size != ALL_ONES_SIZE) ?
						raw_size + 32'd1 : raw_size;
					if (pad_size == 32'd0) begin
						abort_d = 1'b1;
						phase_d = PH_ABORT;
					end else begin
						fcnt_d  = 3'd0;
						accum_d = 64'd0;
						case (chid_q)
							ID_DS64: begin
								ds64_d           = 1'b1;
								mask_d[BIT_DS64] = 1'b1;
								if (pad_size < DS64_MIN) begin
									abort_d = 1'b1;
									phase_d = PH_ABORT;
								end else begin
									skip_d  = {32'd0, pad_size - DS64_MIN};
									phase_d = PH_DS_SKIP8;
								end
							end
							ID_DBMD: begin
								mask_d[BIT_DBMD] = 1'b1;
								if (pad_size > {16'd0, max_meta_q}) begin
									abort_d = 1'b1;
									phase_d = PH_ABORT;
								end else begin
									lmeta_d = pad_size[15:0];
									skip_d  = {32'd0, pad_size};
									phase_d = PH_META;
								end
							end
							default: begin
								if (chid_q == ID_FMT)  mask_d[BIT_FMT]  = 1'b1;
								if (chid_q == ID_DATA) mask_d[BIT_DATA] = 1'b1;
								if (chid_q == ID_AXML) mask_d[BIT_AXML] = 1'b1;
								// RF64 data size comes from ds64
								if (chid_q == ID_DATA && large_q && pad_size == ALL_ONES_SIZE) begin
									skip_d = ldsize_q;
								end else begin
									skip_d = {32'd0, pad_size};
								end
								phase_d = (skip_d == 64'd0) ? PH_CHID : PH_SKIP;
							end
						endcase
					end
				end
			end
			PH_DS_SKIP8: begin
				fcnt_d = fcnt_q + 3'd1;
				if (fcnt_q == 3'd7) begin
					fcnt_d  = 3'd0;
					accum_d = 64'd0;
					phase_d = PH_DS_DATA;
				end
			end
			PH_DS_DATA: begin
				accum_d[{fcnt_q, 3'b000} +: 8] = accum_q[{fcnt_q, 3'b000} +: 8] | byte_s1;
				fcnt_d = fcnt_q + 3'd1;
				if (fcnt_q == 3'd7) begin
					fcnt_d   = 3'd0;
					ldsize_d = accum_d;
					accum_d  = 64'd0;
					phase_d  = (skip_q == 64'd0) ? PH_CHID : PH_SKIP;
				end
			end
			PH_META, PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_last) begin
					phase_d = PH_CHID;
				end
			end
			default: begin
			end
		endcase
	end

	// verdict from the updated state
	always_comb begin
		hdr_fail = abort_d || phase_d == PH_TAG || phase_d == PH_RSIZE || phase_d == PH_WAVE;
		if (hdr_fail) begin
			verdict_ok = 1'b0;
		end else if (large_d && ds64_d) begin
			verdict_ok = (mask_d == MASK_LARGE_OK);
		end else begin
			verdict_ok = (mask_d == MASK_PLAIN_OK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TAG;
			fcnt_q   <= 3'd0;
			chid_q   <= 32'd0;
			accum_q  <= 64'd0;
			skip_q   <= 64'd0;
			mask_q   <= 7'd0;
			large_q  <= 1'b0;
			ds64_q   <= 1'b0;
			ldsize_q <= 64'd0;
			lmeta_q  <= 16'd0;
			abort_q  <= 1'b0;
		end else if (proc && eof_s1) begin
			// file done: back to reset values
			phase_q  <= PH_TAG;
			fcnt_q   <= 3'd0;
			chid_q   <= 32'd0;
			accum_q  <= 64'd0;
			skip_q   <= 64'd0;
			mask_q   <= 7'd0;
			large_q  <= 1'b0;
			ds64_q   <= 1'b0;
			ldsize_q <= 64'd0;
			lmeta_q  <= 16'd0;
			abort_q  <= 1'b0;
		end else if (proc) begin
			phase_q  <= phase_d;
			fcnt_q   <= fcnt_d;
			chid_q   <= chid_d;
			accum_q  <= accum_d;
			skip_q   <= skip_d;
			mask_q   <= mask_d;
			large_q  <= large_d;
			ds64_q   <= ds64_d;
			ldsize_q <= ldsize_d;
			lmeta_q  <= lmeta_d;
			abort_q  <= abort_d;
		end
	end

	// ---------------- result queue ----------------
	res_t              res_meta;
	res_t              res_verd;
	res_t              push0_res;
	logic              push0;
	logic              push1;
	logic [1:0]        n_push;
	logic              pop;
	logic [RES_PW-1:0] wr_ptr_q;
	logic [RES_PW-1:0] rd_ptr_q;
	logic [RES_PW-1:0] wr_ptr_p1;
	res_t              fifo_q [RES_DEPTH];
	res_t              head;

	always_comb begin
		res_meta.is_verdict  = 1'b0;
		res_meta.meta_byte   = byte_s1;
		res_meta.chunk_start = meta_first;
		res_meta.file_ok     = 1'b0;
		res_meta.chunk_flags = mask_q;
		res_meta.meta_size   = lmeta_q;

		res_verd.is_verdict  = 1'b1;
		res_verd.meta_byte   = 8'd0;
		res_verd.chunk_start = 1'b0;
		res_verd.file_ok     = verdict_ok;
		res_verd.chunk_flags = mask_d;
		res_verd.meta_size   = lmeta_d;
	end

	// slot 0 takes the metadata byte if any, else the verdict; slot 1 the
	// verdict when both come from the same byte
	assign push0     = proc && (meta_emit || eof_s1);
	assign push1     = proc && meta_emit && eof_s1;
	assign push0_res = meta_emit ? res_meta : res_verd;
	assign n_push    = {1'b0, push0} + {1'b0, push1};
	assign wr_ptr_p1 = wr_ptr_q + RES_PW'(1);
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		for (int i = 0; i < RES_DEPTH; i++) begin
			if (push0 && wr_ptr_q == RES_PW'(i)) begin
				fifo_q[i] <= push0_res;
			end else if (push1 && wr_ptr_p1 == RES_PW'(i)) begin
				fifo_q[i] <= res_verd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RES_PW'(1);
			end
			count_q <= count_q + RES_CW'(n_push) - RES_CW'(pop);
		end
	end

	assign head        = fifo_q[rd_ptr_q];
	assign out_valid   = (count_q != '0);
	assign is_verdict  = head.is_verdict;
	assign meta_byte   = head.meta_byte;
	assign chunk_start = head.chunk_start;
	assign file_ok     = head.file_ok;
	assign chunk_flags = head.chunk_flags;
	assign meta_size   = head.meta_size;

	// ---------------- assertions ----------------
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RES_CW'(RES_DEPTH))
		else $error("result queue overflow");

	a_abort_phase: assert property (@(posedge clk) disable iff (!arst_n)
		abort_q |-> phase_q == PH_ABORT)
		else $error("aborted flag without abort phase");

	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && eof_s1) |=> (phase_q == PH_TAG && mask_q == 7'd0 && !abort_q))
		else $error("parse state not cleared after verdict");

	a_pass_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_verdict && file_ok) |-> chunk_flags[5:0] == MASK_PLAIN_OK[5:0])
		else $error("passing verdict with required chunk missing");

	a_meta_size: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_META) |-> (skip_q != 64'd0 && skip_q <= {48'd0, lmeta_q}))
		else $error("metadata byte count out of range");

endmodule
